>>> design/kmpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kmpa_pkg;

  localparam int MAX_PIXELS     = 64;
  localparam int MAX_PARTITIONS = 4;
  localparam int NUM_CENTRES    = 4;
  localparam int NUM_CHANNELS   = 4;
  localparam int CHAN_W         = 16;
  localparam int SQ_W           = 2 * CHAN_W;
  localparam int PROD_W         = SQ_W + CHAN_W;
  localparam int DIST_W         = PROD_W + 2;
  localparam int PART_W         = 2;
  localparam int PIX_IDX_W      = 6;
  localparam int NP_W           = 3;
  localparam int PASS_W         = 3;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_W          = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_PCOUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_3 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS  = 3'd5;

  typedef struct packed {
    logic              take;
    logic              sq_en;
    logic              mul_en;
    logic              sum_en;
    logic              pair_en;
    logic              commit;
    logic              fix_rd;
    logic              fix_apply;
    logic [PART_W-1:0] fix_idx;
    logic              emit_rd;
    logic              out_load;
    logic              emit_next;
    logic              block_clear;
  } cmd_t;

  typedef struct packed {
    logic            blk_last;
    logic            fix_empty;
    logic            out_free;
    logic            emit_last;
    logic [NP_W-1:0] limit;
  } sts_t;

endpackage

`default_nettype wire

>>> design/kmpa_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module kmpa_datapath #(
  parameter int MAX_PIXELS = kmpa_pkg::MAX_PIXELS
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   cfg_we,
  input  wire [kmpa_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire [kmpa_pkg::CFG_W-1:0]             cfg_data,
  input  wire [kmpa_pkg::CHAN_W-1:0]            in_red,
  input  wire [kmpa_pkg::CHAN_W-1:0]            in_green,
  input  wire [kmpa_pkg::CHAN_W-1:0]            in_blue,
  input  wire [kmpa_pkg::CHAN_W-1:0]            in_alpha,
  input  wire                                   in_last_pixel,
  input  wire kmpa_pkg::cmd_t                   cmd,
  output kmpa_pkg::sts_t                        sts,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic [kmpa_pkg::PIX_IDX_W-1:0]        out_pixel_index,
  output logic [kmpa_pkg::PART_W-1:0]           out_partition,
  output logic                                  out_last_result
);

  localparam int IDX_W  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
  localparam int NC     = kmpa_pkg::NUM_CENTRES;
  localparam int NCH    = kmpa_pkg::NUM_CHANNELS;
  localparam int CW     = kmpa_pkg::CHAN_W;
  localparam int PW     = kmpa_pkg::PART_W;
  localparam int NPW    = kmpa_pkg::NP_W;

  logic [NPW-1:0]                 pcount_r;
  logic [kmpa_pkg::CFG_W-1:0]     centre_r [NC];
  logic [kmpa_pkg::CFG_W-1:0]     weights_r;
  logic [NPW-1:0]                 np;

  logic [CW-1:0]                  px_r [NCH];
  logic                           last_r;
  logic [CW-1:0]                  diff [NC][NCH];
  logic [kmpa_pkg::SQ_W-1:0]      sq_r [NC][NCH];
  logic [kmpa_pkg::PROD_W-1:0]    prod_r [NC][NCH];
  logic [kmpa_pkg::DIST_W-1:0]    dist_r [NC];

  logic [kmpa_pkg::DIST_W-1:0]    pa_dist_r, pb_dist_r;
  logic [PW-1:0]                  pa_idx_r, pb_idx_r;
  logic                           pb_valid_r;
  logic [PW-1:0]                  best;

  logic [CNT_W-1:0]               pix_cnt_r;
  logic [CNT_W-1:0]               sizes_r [NC];
  logic [CNT_W-1:0]               sizes_nxt [NC];

  logic [PW-1:0]                  store_mem [MAX_PIXELS];
  logic [PW-1:0]                  rd_q_r;
  logic [IDX_W-1:0]               rd_addr;
  logic                           wr_en;
  logic [IDX_W-1:0]               wr_addr;
  logic [PW-1:0]                  wr_data;

  logic [IDX_W-1:0]               emit_idx_r;
  logic                           out_valid_r;
  logic [kmpa_pkg::PIX_IDX_W-1:0] out_pixel_index_r;
  logic [PW-1:0]                  out_partition_r;
  logic                           out_last_result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcount_r  <= NPW'(1);
      weights_r <= '0;
      for (int k = 0; k < NC; k++) begin
        centre_r[k] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        kmpa_pkg::CFG_PCOUNT:   pcount_r    <= cfg_data[NPW-1:0];
        kmpa_pkg::CFG_CENTRE_0: centre_r[0] <= cfg_data;
        kmpa_pkg::CFG_CENTRE_1: centre_r[1] <= cfg_data;
        kmpa_pkg::CFG_CENTRE_2: centre_r[2] <= cfg_data;
        kmpa_pkg::CFG_CENTRE_3: centre_r[3] <= cfg_data;
        kmpa_pkg::CFG_WEIGHTS:  weights_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pcount_r == '0) begin
      np = NPW'(1);
    end else if (pcount_r > NPW'(kmpa_pkg::MAX_PARTITIONS)) begin
      np = NPW'(kmpa_pkg::MAX_PARTITIONS);
    end else begin
      np = pcount_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      px_r[0] <= in_red;
      px_r[1] <= in_green;
      px_r[2] <= in_blue;
      px_r[3] <= in_alpha;
      last_r  <= in_last_pixel;
    end
  end

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      for (int c = 0; c < NCH; c++) begin
        if (px_r[c] >= centre_r[k][CW*c +: CW]) begin
          diff[k][c] = px_r[c] - centre_r[k][CW*c +: CW];
        end else begin
          diff[k][c] = centre_r[k][CW*c +: CW] - px_r[c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NC; k++) begin
      for (int c = 0; c < NCH; c++) begin
        if (cmd.sq_en) begin
          sq_r[k][c] <= diff[k][c] * diff[k][c];
        end
        if (cmd.mul_en) begin
          prod_r[k][c] <= sq_r[k][c] * weights_r[CW*c +: CW];
        end
      end
      if (cmd.sum_en) begin
        dist_r[k] <= kmpa_pkg::DIST_W'(prod_r[k][0]) + kmpa_pkg::DIST_W'(prod_r[k][1])
                   + kmpa_pkg::DIST_W'(prod_r[k][2]) + kmpa_pkg::DIST_W'(prod_r[k][3]);
      end
    end
  end

  // pair winners; lower index keeps ties
  always_ff @(posedge clk) begin
    if (cmd.pair_en) begin
      if (np > NPW'(1) && dist_r[1] < dist_r[0]) begin
        pa_dist_r <= dist_r[1];
        pa_idx_r  <= PW'(1);
      end else begin
        pa_dist_r <= dist_r[0];
        pa_idx_r  <= PW'(0);
      end
      if (np > NPW'(3) && dist_r[3] < dist_r[2]) begin
        pb_dist_r <= dist_r[3];
        pb_idx_r  <= PW'(3);
      end else begin
        pb_dist_r <= dist_r[2];
        pb_idx_r  <= PW'(2);
      end
      pb_valid_r <= (np > NPW'(2));
    end
  end

  assign best = (pb_valid_r && pb_dist_r < pa_dist_r) ? pb_idx_r : pa_idx_r;

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      sizes_nxt[k] = sizes_r[k];
    end
    if (cmd.commit) begin
      sizes_nxt[best] = sizes_r[best] + CNT_W'(1);
    end
    if (cmd.fix_apply && sts.fix_empty) begin
      if (sizes_nxt[rd_q_r] != '0) begin
        sizes_nxt[rd_q_r] = sizes_nxt[rd_q_r] - CNT_W'(1);
      end
      sizes_nxt[cmd.fix_idx] = sizes_nxt[cmd.fix_idx] + CNT_W'(1);
    end
    if (cmd.block_clear) begin
      for (int k = 0; k < NC; k++) begin
        sizes_nxt[k] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_cnt_r  <= '0;
      emit_idx_r <= '0;
      for (int k = 0; k < NC; k++) begin
        sizes_r[k] <= '0;
      end
    end else begin
      for (int k = 0; k < NC; k++) begin
        sizes_r[k] <= sizes_nxt[k];
      end
      if (cmd.block_clear) begin
        pix_cnt_r  <= '0;
        emit_idx_r <= '0;
      end else begin
        if (cmd.commit) begin
          pix_cnt_r <= pix_cnt_r + CNT_W'(1);
        end
        if (cmd.emit_next) begin
          emit_idx_r <= emit_idx_r + IDX_W'(1);
        end
      end
    end
  end

  assign wr_en   = cmd.commit || (cmd.fix_apply && sts.fix_empty);
  assign wr_addr = cmd.commit ? IDX_W'(pix_cnt_r) : IDX_W'(cmd.fix_idx);
  assign wr_data = cmd.commit ? best : cmd.fix_idx;
  assign rd_addr = cmd.fix_rd ? IDX_W'(cmd.fix_idx) : emit_idx_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fix_rd || cmd.emit_rd) begin
      rd_q_r <= store_mem[rd_addr];
    end
  end

  always_comb begin
    sts.blk_last  = last_r || (8'(pix_cnt_r) + 8'd1 >= 8'(MAX_PIXELS));
    sts.fix_empty = (sizes_r[cmd.fix_idx] == '0);
    sts.out_free  = !out_valid_r || !out_stall;
    sts.emit_last = (8'(emit_idx_r) + 8'd1 == 8'(pix_cnt_r));
    if (8'(pix_cnt_r) < 8'(np)) begin
      sts.limit = NPW'(pix_cnt_r);
    end else begin
      sts.limit = np;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_pixel_index_r <= kmpa_pkg::PIX_IDX_W'(emit_idx_r);
      out_partition_r   <= rd_q_r;
      out_last_result_r <= sts.emit_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_index = out_pixel_index_r;
  assign out_partition   = out_partition_r;
  assign out_last_result = out_last_result_r;

endmodule

`default_nettype wire

>>> design/kmpa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module kmpa_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire kmpa_pkg::sts_t sts,
  output kmpa_pkg::cmd_t      cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SQ      = 4'd1;
  localparam logic [3:0] S_MUL     = 4'd2;
  localparam logic [3:0] S_SUM     = 4'd3;
  localparam logic [3:0] S_PAIR    = 4'd4;
  localparam logic [3:0] S_CMP     = 4'd5;
  localparam logic [3:0] S_FIX_RD  = 4'd6;
  localparam logic [3:0] S_FIX_UP  = 4'd7;
  localparam logic [3:0] S_EMIT_RD = 4'd8;
  localparam logic [3:0] S_EMIT_LD = 4'd9;

  localparam int PW  = kmpa_pkg::PART_W;
  localparam int NPW = kmpa_pkg::NP_W;
  localparam int SW  = kmpa_pkg::PASS_W;

  logic [3:0]    state_r, state_nxt;
  logic [PW-1:0] fix_i_r, fix_i_nxt;
  logic [SW-1:0] pass_r, pass_nxt;
  logic          changed_r, changed_nxt;
  logic          any_change;

  assign in_stall   = (state_r != S_IDLE);
  assign any_change = changed_r || sts.fix_empty;

  always_comb begin
    state_nxt   = state_r;
    fix_i_nxt   = fix_i_r;
    pass_nxt    = pass_r;
    changed_nxt = changed_r;
    cmd         = '0;
    cmd.fix_idx = fix_i_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        cmd.sq_en = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_SUM;
      end
      S_SUM: begin
        cmd.sum_en = 1'b1;
        state_nxt  = S_PAIR;
      end
      S_PAIR: begin
        cmd.pair_en = 1'b1;
        state_nxt   = S_CMP;
      end
      S_CMP: begin
        cmd.commit = 1'b1;
        if (sts.blk_last) begin
          fix_i_nxt   = '0;
          pass_nxt    = '0;
          changed_nxt = 1'b0;
          state_nxt   = S_FIX_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_FIX_RD: begin
        cmd.fix_rd = 1'b1;
        state_nxt  = S_FIX_UP;
      end
      S_FIX_UP: begin
        cmd.fix_apply = 1'b1;
        changed_nxt   = any_change;
        state_nxt     = S_FIX_RD;
        if (NPW'(fix_i_r) + NPW'(1) == sts.limit) begin
          fix_i_nxt = '0;
          if (!any_change || pass_r == SW'(kmpa_pkg::MAX_PARTITIONS)) begin
            state_nxt = S_EMIT_RD;
          end else begin
            pass_nxt    = pass_r + SW'(1);
            changed_nxt = 1'b0;
          end
        end else begin
          fix_i_nxt = fix_i_r + PW'(1);
        end
      end
      S_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_nxt   = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.emit_last) begin
            cmd.block_clear = 1'b1;
            state_nxt       = S_IDLE;
          end else begin
            cmd.emit_next = 1'b1;
            state_nxt     = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      fix_i_r   <= '0;
      pass_r    <= '0;
      changed_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fix_i_r   <= fix_i_nxt;
      pass_r    <= pass_nxt;
      changed_r <= changed_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/kmeans_partition_assign_core.sv
// Weighted k-means assignment for one block of RGBA pixels.
// Configuration: write partition_count, the four centres and channel_weights
// through cfg_we/cfg_index/cfg_data while the block is idle.
// Input channel: one pixel per transaction on in_valid/in_stall, with
// in_last_pixel marking the final pixel (the MAX_PIXELS-th pixel always ends
// the block). After a pixel is accepted, the next is not accepted until the
// pixel has been captured, then squared, weighted, summed, pair compared and
// final compared, one register stage each.
// At the end of a block a fix-up runs over the partition sizes: a store read,
// then the update, for each partition checked, at most 5 passes over at most
// 4 partitions.
// Output channel: one transaction per pixel of the block, in order, on
// out_valid/out_stall; out_last_result marks the final one. Each result takes
// a store read, then an output load, through the store's single read port.
// A stalled result holds in the output register; emission waits for it. The
// last result of a block may sit there while the next block's pixels load.
// Reset (rst_n low, synchronous) clears the configuration to its defaults,
// the counts and the control state; no pixel is held after reset.
`timescale 1ns / 1ps
`default_nettype none

module kmeans_partition_assign_core #(
  parameter int MAX_PIXELS = kmpa_pkg::MAX_PIXELS
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  cfg_we,
  input  wire [kmpa_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire [kmpa_pkg::CFG_W-1:0]            cfg_data,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire [kmpa_pkg::CHAN_W-1:0]           in_red,
  input  wire [kmpa_pkg::CHAN_W-1:0]           in_green,
  input  wire [kmpa_pkg::CHAN_W-1:0]           in_blue,
  input  wire [kmpa_pkg::CHAN_W-1:0]           in_alpha,
  input  wire                                  in_last_pixel,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic [kmpa_pkg::PIX_IDX_W-1:0]       out_pixel_index,
  output logic [kmpa_pkg::PART_W-1:0]          out_partition,
  output logic                                 out_last_result
);

  kmpa_pkg::cmd_t cmd;
  kmpa_pkg::sts_t sts;

  kmpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  kmpa_datapath #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .in_alpha        (in_alpha),
    .in_last_pixel   (in_last_pixel),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_index (out_pixel_index),
    .out_partition   (out_partition),
    .out_last_result (out_last_result)
  );

endmodule

`default_nettype wire

>>> verif/kmpa_assign_checker.sv
`timescale 1ns / 1ps

module kmpa_assign_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [kmpa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kmpa_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [kmpa_pkg::CHAN_W-1:0]       in_red,
  input  logic [kmpa_pkg::CHAN_W-1:0]       in_green,
  input  logic [kmpa_pkg::CHAN_W-1:0]       in_blue,
  input  logic [kmpa_pkg::CHAN_W-1:0]       in_alpha,
  input  logic                              in_last_pixel,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [kmpa_pkg::PIX_IDX_W-1:0]    out_pixel_index,
  input  logic [kmpa_pkg::PART_W-1:0]       out_partition,
  input  logic                              out_last_result,
  output int                                mismatches,
  output int                                awaiting
);
  import kmpa_pkg::*;

  typedef struct packed {
    logic [PIX_IDX_W-1:0] pixel_index;
    logic [PART_W-1:0]    partition;
    logic                 last_result;
  } assignment_t;

  logic [NP_W-1:0]   pcount_reg;
  logic [CFG_W-1:0]  centre_reg [NUM_CENTRES];
  logic [CFG_W-1:0]  weight_reg;
  logic [PART_W-1:0] block_parts [MAX_PIXELS];
  int                part_size [MAX_PARTITIONS];
  int                block_fill;
  int                fail_count;
  assignment_t       expected_q [$];

  function automatic int active_parts();
    if (pcount_reg == 0) return 1;
    if (pcount_reg > MAX_PARTITIONS) return MAX_PARTITIONS;
    return int'(pcount_reg);
  endfunction

  function automatic logic [63:0] weighted_dist(input logic [CFG_W-1:0] pix,
                                                input logic [CFG_W-1:0] ctr);
    logic [CHAN_W-1:0] a;
    logic [CHAN_W-1:0] b;
    logic [CHAN_W-1:0] d;
    logic [63:0]       sum;
    sum = '0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      a = pix[CHAN_W*c +: CHAN_W];
      b = ctr[CHAN_W*c +: CHAN_W];
      d = (a >= b) ? a - b : b - a;
      sum = sum + {48'd0, d} * {48'd0, d} * {48'd0, weight_reg[CHAN_W*c +: CHAN_W]};
    end
    return sum;
  endfunction

  // settle empty partitions, then queue one assignment per pixel of the block
  task automatic close_block();
    int               n;
    int               lim;
    int               pass;
    bit               moved;
    logic [PART_W-1:0] prev;
    assignment_t      item;
    n = block_fill;
    lim = (active_parts() < n) ? active_parts() : n;
    for (pass = 0; pass <= MAX_PARTITIONS; pass++) begin
      moved = 1'b0;
      for (int i = 0; i < lim; i++) begin
        if (part_size[i] == 0) begin
          prev = block_parts[i];
          if (part_size[prev] > 0) part_size[prev]--;
          part_size[i]++;
          block_parts[i] = PART_W'(i);
          moved = 1'b1;
        end
      end
      if (!moved) break;
    end
    for (int i = 0; i < n; i++) begin
      item.pixel_index = PIX_IDX_W'(i);
      item.partition   = block_parts[i];
      item.last_result = (i == n - 1);
      expected_q.push_back(item);
    end
    foreach (part_size[k]) part_size[k] = 0;
    block_fill = 0;
  endtask

  task automatic load_pixel(input logic [CFG_W-1:0] pix, input logic last);
    logic [63:0] best_d;
    logic [63:0] d;
    int          best;
    best = 0;
    best_d = weighted_dist(pix, centre_reg[0]);
    for (int j = 1; j < active_parts(); j++) begin
      d = weighted_dist(pix, centre_reg[j]);
      if (d < best_d) begin
        best_d = d;
        best = j;
      end
    end
    block_parts[block_fill] = PART_W'(best);
    part_size[best]++;
    block_fill++;
    if (last || block_fill >= MAX_PIXELS) close_block();
  endtask

  task automatic compare_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
    end
  endtask

  task automatic check_result();
    assignment_t want;
    if (expected_q.size() == 0) begin
      fail_count++;
      $display("%0t: result expected none actual pixel_index=%0d partition=%0d last=%0b",
               $time, out_pixel_index, out_partition, out_last_result);
    end else begin
      want = expected_q.pop_front();
      compare_field("pixel_index", want.pixel_index, out_pixel_index);
      compare_field("partition", want.partition, out_partition);
      compare_field("last_result", want.last_result, out_last_result);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pcount_reg = NP_W'(1);
      foreach (centre_reg[k]) centre_reg[k] = '0;
      weight_reg = '0;
      foreach (part_size[k]) part_size[k] = 0;
      block_fill = 0;
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PCOUNT:   pcount_reg = cfg_data[NP_W-1:0];
          CFG_CENTRE_0: centre_reg[0] = cfg_data;
          CFG_CENTRE_1: centre_reg[1] = cfg_data;
          CFG_CENTRE_2: centre_reg[2] = cfg_data;
          CFG_CENTRE_3: centre_reg[3] = cfg_data;
          CFG_WEIGHTS:  weight_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        load_pixel({in_alpha, in_blue, in_green, in_red}, in_last_pixel);
      if (out_valid && !out_stall) check_result();
    end
    mismatches <= fail_count;
    awaiting <= expected_q.size();
  end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import kmpa_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 3'd7;
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_PIXELS = 125;
  localparam int CALM_FROM     = 100;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [CHAN_W-1:0]    in_red = '0;
  logic [CHAN_W-1:0]    in_green = '0;
  logic [CHAN_W-1:0]    in_blue = '0;
  logic [CHAN_W-1:0]    in_alpha = '0;
  logic                 in_last_pixel = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [PIX_IDX_W-1:0] out_pixel_index;
  logic [PART_W-1:0]    out_partition;
  logic                 out_last_result;

  int               mismatches;
  int               awaiting;
  bit               idle_on = 1'b1;
  int               stall_left = 0;
  int               random_sent = 0;
  logic [CFG_W-1:0] cur_centre [NUM_CENTRES] = '{default: '0};

  kmeans_partition_assign_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .in_alpha        (in_alpha),
    .in_last_pixel   (in_last_pixel),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_index (out_pixel_index),
    .out_partition   (out_partition),
    .out_last_result (out_last_result)
  );

  kmpa_assign_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .in_alpha        (in_alpha),
    .in_last_pixel   (in_last_pixel),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_index (out_pixel_index),
    .out_partition   (out_partition),
    .out_last_result (out_last_result),
    .mismatches      (mismatches),
    .awaiting        (awaiting)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic logic [CFG_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [CFG_W-1:0] make_pixel();
    logic [CFG_W-1:0] pix;
    pix = cur_centre[$urandom_range(0, NUM_CENTRES - 1)];
    case ($urandom_range(0, 5))
      0: ;
      1, 2: begin
        for (int c = 0; c < NUM_CHANNELS; c++)
          pix[CHAN_W*c +: CHAN_W] = pix[CHAN_W*c +: CHAN_W]
                                    + CHAN_W'($urandom_range(0, 31)) - CHAN_W'(16);
      end
      3: begin
        for (int c = 0; c < NUM_CHANNELS; c++)
          pix[CHAN_W*c +: CHAN_W] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      end
      default: pix = rand64();
    endcase
    return pix;
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_W-1:0] pcount, c0, c1, c2, c3, weights,
                            input bit poke_unmapped);
    cfg_write(CFG_PCOUNT, pcount);
    cfg_write(CFG_CENTRE_0, c0);
    cfg_write(CFG_CENTRE_1, c1);
    cfg_write(CFG_CENTRE_2, c2);
    cfg_write(CFG_CENTRE_3, c3);
    cfg_write(CFG_WEIGHTS, weights);
    if (poke_unmapped) begin
      cfg_write(CFG_UNMAPPED_LO, rand64());
      cfg_write(CFG_UNMAPPED_HI, '1);
    end
    cfg_we <= 1'b0;
    cur_centre[0] = c0;
    cur_centre[1] = c1;
    cur_centre[2] = c2;
    cur_centre[3] = c3;
  endtask

  task automatic shuffle_config();
    logic [CFG_W-1:0] ctr [NUM_CENTRES];
    logic [CFG_W-1:0] w;
    int               pc;
    pc = $urandom_range(0, 9);
    if (pc > 7) pc = MAX_PARTITIONS;
    for (int k = 0; k < NUM_CENTRES; k++) begin
      case ($urandom_range(0, 3))
        0: ctr[k] = (k > 0) ? ctr[$urandom_range(0, k - 1)] : rand64();
        1: begin
          for (int c = 0; c < NUM_CHANNELS; c++)
            ctr[k][CHAN_W*c +: CHAN_W] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end
        default: ctr[k] = rand64();
      endcase
    end
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      case ($urandom_range(0, 4))
        0: w[CHAN_W*c +: CHAN_W] = 16'h0000;
        1: w[CHAN_W*c +: CHAN_W] = 16'hFFFF;
        2: w[CHAN_W*c +: CHAN_W] = 16'h0100;
        default: w[CHAN_W*c +: CHAN_W] = CHAN_W'($urandom_range(0, 65535));
      endcase
    end
    set_config((rand64() & ~64'h7) | CFG_W'(pc), ctr[0], ctr[1], ctr[2], ctr[3], w,
               $urandom_range(0, 2) == 0);
  endtask

  task automatic send_pixel(input logic [CFG_W-1:0] pix, input logic last);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    {in_alpha, in_blue, in_green, in_red} <= pix;
    in_last_pixel <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold off until every assignment has come back and the pipeline is empty
  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int size;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_pixel({4{16'hFFFF}}, 1'b0);
    send_pixel('0, 1'b1);
    quiesce();

    set_config(64'd4, '0, {4{16'hFFFF}}, 64'h0000_FFFF_0000_FFFF, {4{16'h8000}},
               {4{16'hFFFF}}, 1'b0);
    send_pixel('0, 1'b0);
    send_pixel({4{16'hFFFF}}, 1'b0);
    send_pixel(64'h0000_FFFF_0000_FFFF, 1'b0);
    send_pixel({4{16'h8000}}, 1'b1);
    send_pixel({4{16'hFFFF}}, 1'b1);
    quiesce();

    set_config(64'd4, {4{16'h1234}}, {4{16'h1234}}, {4{16'h1234}}, {4{16'h1234}},
               {4{16'h0100}}, 1'b0);
    repeat (4) send_pixel(rand64(), 1'b0);
    send_pixel(rand64(), 1'b1);
    quiesce();

    set_config(64'd3, '0, {4{16'h8000}}, {4{16'hFFFF}}, rand64(), {4{16'h0001}}, 1'b0);
    send_pixel({4{16'hFFFF}}, 1'b0);
    send_pixel('0, 1'b0);
    send_pixel({4{16'hF000}}, 1'b1);
    quiesce();

    set_config(64'd7, 64'h0000_1111_2222_3333, 64'h4000_1111_2222_3333,
               64'hC000_1111_2222_3333, 64'hFFFF_1111_2222_3333,
               64'hFFFF_0000_0000_0000, 1'b1);
    send_pixel(rand64(), 1'b0);
    send_pixel(rand64(), 1'b0);
    send_pixel(rand64(), 1'b1);
    quiesce();

    set_config(64'hFFFF_FFFF_FFFF_FFF8, rand64(), rand64(), rand64(), rand64(),
               rand64(), 1'b0);
    send_pixel(rand64(), 1'b0);
    send_pixel(rand64(), 1'b1);
    quiesce();

    // block of full size with no end marker: the last slot closes it
    shuffle_config();
    for (int k = 0; k < MAX_PIXELS; k++) send_pixel(make_pixel(), 1'b0);
    random_sent += MAX_PIXELS;

    while (random_sent < RANDOM_PIXELS) begin
      quiesce();
      idle_on = (random_sent < CALM_FROM) && ($urandom_range(0, 2) != 0);
      shuffle_config();
      repeat ($urandom_range(1, 4)) begin
        size = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        for (int k = 0; k < size; k++) send_pixel(make_pixel(), k == size - 1);
        random_sent += size;
      end
    end

    quiesce();
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
